[hdl/string_hash_bank_top_macros.svh]
// Assertion macros shared by the string hash bank modules.
`ifndef STRING_HASH_BANK_TOP_MACROS_SVH
`define STRING_HASH_BANK_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define SHB_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("string hash bank: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SHB_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("string hash bank: next-cycle check failed");
`else
`define SHB_ASSERT_IMPL(label, ck, rn, ante, cons)
`define SHB_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

[hdl/shb_pkg.sv]
package shb_pkg;

    localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
    localparam logic [31:0] FNV_PRIME         = 32'd16777619;
    localparam logic [31:0] AP_MASK           = 32'h7FFF_FFFF;
    localparam logic [31:0] MYSQL_LOW_MASK    = 32'd63;
    localparam logic [31:0] MYSQL_FIRST_INIT  = 32'd1;
    localparam logic [31:0] MYSQL_SECOND_INIT = 32'd4;
    localparam logic [31:0] MYSQL_SECOND_STEP = 32'd3;
    localparam logic [31:0] TIMES_N_RESET     = 32'd131;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        logic [31:0] times33_hash;
        logic [31:0] times_n_hash;
        logic [30:0] ap_hash;
        logic [31:0] fnv_hash;
        logic [31:0] mysql_hash;
        logic [31:0] crc_value;
    } result_t;

    // One entry of the reflected CRC-32 byte table.
    function automatic logic [31:0] crc_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int k = 0; k < 8; k++)
        begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

[hdl/string_hash_bank_top.sv]
// Channel   Handshake               Payload
// input     in_valid / in_ready     data_byte, byte_present, end_of_string
// result    out_valid / out_ready   times33_hash, times_n_hash, ap_hash,
//                                   fnv_hash, mysql_hash, crc_value
// config    cfg_valid / cfg_ready   times_n_multiplier
//
// One request per cycle is taken unless a waiting result stalls it; the hash
// recurrences are combinational between the input register and the accumulators.
// A string's last request is held in the input register, then its result in the result register.
// cfg_ready is always high; the multiplier resets to 131.
// A waiting result stalls only a request that ends a string; bytes keep
// flowing into the accumulators meanwhile.
module string_hash_bank_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] times33_hash,
    output logic [31:0] times_n_hash,
    output logic [30:0] ap_hash,
    output logic [31:0] fnv_hash,
    output logic [31:0] mysql_hash,
    output logic [31:0] crc_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] times_n_multiplier
);

    logic             item_valid;
    shb_pkg::item_t   item;
    logic             item_take;
    logic             out_space;
    logic             result_load;
    shb_pkg::result_t result;
    shb_pkg::result_t result_out;

    shb_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .end_of_string(end_of_string),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    shb_hash_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .times_n_multiplier(times_n_multiplier),
        .item_valid        (item_valid),
        .item              (item),
        .item_take         (item_take),
        .out_space         (out_space),
        .result_load       (result_load),
        .result            (result)
    );

    shb_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .result_load(result_load),
        .result     (result),
        .out_space  (out_space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign times33_hash = result_out.times33_hash;
    assign times_n_hash = result_out.times_n_hash;
    assign ap_hash      = result_out.ap_hash;
    assign fnv_hash     = result_out.fnv_hash;
    assign mysql_hash   = result_out.mysql_hash;
    assign crc_value    = result_out.crc_value;

endmodule

[hdl/shb_in_stage.sv]
`include "string_hash_bank_top_macros.svh"

module shb_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          byte_present,
    input  logic          end_of_string,
    output logic          item_valid,
    output shb_pkg::item_t item,
    input  logic          item_take
);

    logic           valid_reg;
    logic           valid_next;
    shb_pkg::item_t item_reg;
    logic           in_accept;

    assign in_ready  = !valid_reg || item_take;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= '{data_byte: data_byte, byte_present: byte_present,
                          end_of_string: end_of_string};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    // A held request is not lost while the core stalls it.
    `SHB_ASSERT_NEXT(a_in_hold, clk, rst_n, valid_reg && !item_take, valid_reg && $stable(item_reg))

endmodule

[hdl/shb_hash_core.sv]
`include "string_hash_bank_top_macros.svh"

module shb_hash_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      times_n_multiplier,
    input  logic             item_valid,
    input  shb_pkg::item_t   item,
    output logic             item_take,
    input  logic             out_space,
    output logic             result_load,
    output shb_pkg::result_t result
);

    logic [31:0] mult_reg;
    logic [31:0] t33_reg, tn_reg, ap_reg, fnv_reg, my1_reg, my2_reg, crc_reg;
    logic        odd_reg;

    logic [31:0] t33_next, tn_next, ap_next, fnv_next, my1_next, my2_next, crc_next;
    logic        odd_next;

    logic [31:0] b32;
    logic [31:0] t33_upd, tn_upd, ap_upd, fnv_upd, my1_upd, my2_upd, crc_upd;
    logic [31:0] tn_prod, fnv_prod, my_sum, ap_mix;
    logic [31:0] my_prod;
    logic        absorb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= shb_pkg::TIMES_N_RESET;
        end
        else if (cfg_valid)
        begin
            mult_reg <= times_n_multiplier;
        end
    end

    // A request that closes a string needs room in the result register.
    assign item_take   = item_valid && (!item.end_of_string || out_space);
    assign result_load = item_take && item.end_of_string;
    assign absorb      = item_take && item.byte_present;

    assign b32      = {24'd0, item.data_byte};
    assign t33_upd  = (t33_reg << 5) + t33_reg + b32;
    assign tn_prod  = tn_reg * mult_reg;
    assign tn_upd   = tn_prod + b32;
    assign fnv_prod = fnv_reg * shb_pkg::FNV_PRIME;
    assign fnv_upd  = fnv_prod ^ b32;
    assign my_sum   = (my1_reg & shb_pkg::MYSQL_LOW_MASK) + my2_reg;
    assign my_prod  = my_sum * b32;
    assign my1_upd  = my1_reg ^ (my_prod + (my1_reg << 8));
    assign my2_upd  = my2_reg + shb_pkg::MYSQL_SECOND_STEP;
    assign crc_upd  = shb_pkg::crc_entry(crc_reg[7:0] ^ item.data_byte) ^ (crc_reg >> 8);

    // Even positions use the shift-left-7 rule, odd ones the inverted
    // shift-left-11 rule.
    assign ap_mix = odd_reg ? ~((ap_reg << 11) ^ b32 ^ (ap_reg >> 5))
                            : ((ap_reg << 7) ^ b32 ^ (ap_reg >> 3));
    assign ap_upd = ap_reg ^ ap_mix;

    always_comb
    begin
        t33_next = t33_reg;
        tn_next  = tn_reg;
        ap_next  = ap_reg;
        odd_next = odd_reg;
        fnv_next = fnv_reg;
        my1_next = my1_reg;
        my2_next = my2_reg;
        crc_next = crc_reg;
        if (absorb)
        begin
            t33_next = t33_upd;
            tn_next  = tn_upd;
            ap_next  = ap_upd;
            odd_next = !odd_reg;
            fnv_next = fnv_upd;
            my1_next = my1_upd;
            my2_next = my2_upd;
            crc_next = crc_upd;
        end

        result.times33_hash = t33_next;
        result.times_n_hash = tn_next;
        result.ap_hash      = ap_next[30:0];
        result.fnv_hash     = fnv_next;
        result.mysql_hash   = my1_next;
        result.crc_value    = ~crc_next;

        if (result_load)
        begin
            t33_next = '0;
            tn_next  = '0;
            ap_next  = '0;
            odd_next = 1'b0;
            fnv_next = '0;
            my1_next = shb_pkg::MYSQL_FIRST_INIT;
            my2_next = shb_pkg::MYSQL_SECOND_INIT;
            crc_next = shb_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t33_reg <= '0;
            tn_reg  <= '0;
            ap_reg  <= '0;
            odd_reg <= 1'b0;
            fnv_reg <= '0;
            my1_reg <= shb_pkg::MYSQL_FIRST_INIT;
            my2_reg <= shb_pkg::MYSQL_SECOND_INIT;
            crc_reg <= shb_pkg::CRC_INIT;
        end
        else
        begin
            t33_reg <= t33_next;
            tn_reg  <= tn_next;
            ap_reg  <= ap_next;
            odd_reg <= odd_next;
            fnv_reg <= fnv_next;
            my1_reg <= my1_next;
            my2_reg <= my2_next;
            crc_reg <= crc_next;
        end
    end

    `SHB_ASSERT_NEXT(a_core_clear, clk, rst_n, result_load, crc_reg == shb_pkg::CRC_INIT && my2_reg == shb_pkg::MYSQL_SECOND_INIT && !odd_reg)
    `SHB_ASSERT_NEXT(a_core_step, clk, rst_n, absorb && !result_load, my2_reg == $past(my2_reg) + shb_pkg::MYSQL_SECOND_STEP)
    `SHB_ASSERT_NEXT(a_core_idle, clk, rst_n, !item_take, $stable(crc_reg) && $stable(fnv_reg) && $stable(odd_reg))

endmodule

[hdl/shb_out_stage.sv]
`include "string_hash_bank_top_macros.svh"

module shb_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_load,
    input  shb_pkg::result_t result,
    output logic             out_space,
    output logic             out_valid,
    input  logic             out_ready,
    output shb_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    shb_pkg::result_t result_reg;

    assign out_space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    // A new result never overwrites one that has not been taken.
    `SHB_ASSERT_IMPL(a_out_no_overwrite, clk, rst_n, result_load, !valid_reg || out_ready)

endmodule

[bench/string_hash_bank_top_tb.sv]
module string_hash_bank_top_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        byte_present = 1'b0;
    logic        end_of_string = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] times33_hash;
    logic [31:0] times_n_hash;
    logic [30:0] ap_hash;
    logic [31:0] fnv_hash;
    logic [31:0] mysql_hash;
    logic [31:0] crc_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] times_n_multiplier = 32'd0;

    string_hash_bank_top u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .byte_present       (byte_present),
        .end_of_string      (end_of_string),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .times33_hash       (times33_hash),
        .times_n_hash       (times_n_hash),
        .ap_hash            (ap_hash),
        .fnv_hash           (fnv_hash),
        .mysql_hash         (mysql_hash),
        .crc_value          (crc_value),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .times_n_multiplier (times_n_multiplier)
    );

    always #5 clk = ~clk;

    // Running hash state as the block should hold it.
    logic [31:0] sum_times33   = 32'd0;
    logic [31:0] sum_times_n   = 32'd0;
    logic [31:0] sum_ap        = 32'd0;
    logic        ap_odd_byte   = 1'b0;
    logic [31:0] sum_fnv       = 32'd0;
    logic [31:0] mysql_word    = shb_pkg::MYSQL_FIRST_INIT;
    logic [31:0] mysql_add     = shb_pkg::MYSQL_SECOND_INIT;
    logic [31:0] crc_reg       = shb_pkg::CRC_INIT;
    logic [31:0] multiplier    = shb_pkg::TIMES_N_RESET;

    shb_pkg::item_t   string_requests[$];
    shb_pkg::result_t expected_hashes[$];
    shb_pkg::item_t   next_request;
    int      requests_queued = 0;
    int      requests_taken = 0;
    int      mismatches = 0;
    int      send_gap = 0;
    int      recv_stall = 0;
    int      long_hold_cycles = 0;
    bit      no_idle_stretch = 1'b0;

    function automatic logic [31:0] crc_after_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] v;
        v = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            v = v[0] ? ((v >> 1) ^ shb_pkg::CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    task automatic clear_hash_state();
        sum_times33 = 32'd0;
        sum_times_n = 32'd0;
        sum_ap      = 32'd0;
        ap_odd_byte = 1'b0;
        sum_fnv     = 32'd0;
        mysql_word  = shb_pkg::MYSQL_FIRST_INIT;
        mysql_add   = shb_pkg::MYSQL_SECOND_INIT;
        crc_reg     = shb_pkg::CRC_INIT;
    endtask

    task automatic hash_request(input logic [7:0] b, input logic present, input logic last);
        logic [31:0]      bw;
        shb_pkg::result_t res;
        bw = {24'd0, b};
        if (present)
        begin
            sum_times33 = (sum_times33 << 5) + sum_times33 + bw;
            sum_times_n = sum_times_n * multiplier + bw;
            if (ap_odd_byte)
                sum_ap = sum_ap ^ ~((sum_ap << 11) ^ bw ^ (sum_ap >> 5));
            else
                sum_ap = sum_ap ^ ((sum_ap << 7) ^ bw ^ (sum_ap >> 3));
            ap_odd_byte = ~ap_odd_byte;
            sum_fnv = (sum_fnv * shb_pkg::FNV_PRIME) ^ bw;
            mysql_word = mysql_word
                ^ ((((mysql_word & shb_pkg::MYSQL_LOW_MASK) + mysql_add) * bw)
                   + (mysql_word << 8));
            mysql_add = mysql_add + shb_pkg::MYSQL_SECOND_STEP;
            crc_reg = crc_after_byte(crc_reg, b);
        end
        if (last)
        begin
            res.times33_hash = sum_times33;
            res.times_n_hash = sum_times_n;
            res.ap_hash      = sum_ap[30:0];
            res.fnv_hash     = sum_fnv;
            res.mysql_hash   = mysql_word;
            res.crc_value    = ~crc_reg;
            expected_hashes.push_back(res);
            clear_hash_state();
        end
    endtask

    // Request driver: one idle gap drawn per request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hash_request(data_byte, byte_present, end_of_string);
                requests_taken++;
                send_gap = no_idle_stretch ? 0 : $urandom_range(0, 6);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (string_requests.size() > 0)
                begin
                    next_request = string_requests.pop_front();
                    in_valid      <= 1'b1;
                    data_byte     <= next_request.data_byte;
                    byte_present  <= next_request.byte_present;
                    end_of_string <= next_request.end_of_string;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            mismatches++;
        end
    endtask

    // Result monitor: draws a stall per result and honors the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: result with no request waiting, expected none, actual crc %h",
                             $time, crc_value);
                    mismatches++;
                end
                else
                begin
                    check_field("times33_hash", expected_hashes[0].times33_hash, times33_hash);
                    check_field("times_n_hash", expected_hashes[0].times_n_hash, times_n_hash);
                    check_field("ap_hash", {1'b0, expected_hashes[0].ap_hash}, {1'b0, ap_hash});
                    check_field("fnv_hash", expected_hashes[0].fnv_hash, fnv_hash);
                    check_field("mysql_hash", expected_hashes[0].mysql_hash, mysql_hash);
                    check_field("crc_value", expected_hashes[0].crc_value, crc_value);
                    void'(expected_hashes.pop_front());
                end
                recv_stall = no_idle_stretch ? 0 : $urandom_range(0, 6);
            end
            if (long_hold_cycles > 0)
            begin
                long_hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_request(input logic [7:0] b, input logic present, input logic last);
        shb_pkg::item_t r;
        r.data_byte     = b;
        r.byte_present  = present;
        r.end_of_string = last;
        string_requests.push_back(r);
        requests_queued++;
    endtask

    // Mostly short strings, a few long ones, with ignored bytes sprinkled in.
    task automatic queue_random_strings(input int budget);
        int  used;
        int  len;
        int  pick;
        bit  close_with_byte;
        used = 0;
        while (used < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(0, 12);
            else if (pick < 95)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 90);
            close_with_byte = (len > 0) && ($urandom_range(0, 99) < 80);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    used++;
                end
                push_request(8'($urandom_range(0, 255)), 1'b1,
                             close_with_byte && (i == len - 1));
                used++;
            end
            if (!close_with_byte)
            begin
                push_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                used++;
            end
        end
        // Sometimes leave a string open so it continues under the next multiplier.
        if ($urandom_range(0, 1) == 1)
        begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                push_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
    endtask

    task automatic wait_all_sent_and_checked();
        while (requests_taken != requests_queued || expected_hashes.size() != 0)
            @(negedge clk);
    endtask

    // The block may still be absorbing a byte after the last result, so let it settle.
    task automatic wait_block_idle();
        wait_all_sent_and_checked();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_multiplier(input logic [31:0] value);
        @(posedge clk);
        cfg_valid          <= 1'b1;
        times_n_multiplier <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        multiplier = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings under the reset multiplier.
        push_request(8'hA5, 1'b0, 1'b1);
        push_request(8'hFF, 1'b0, 1'b0);
        push_request(8'h00, 1'b1, 1'b1);
        push_request(8'hFF, 1'b1, 1'b1);
        push_request(8'h61, 1'b1, 1'b0);
        push_request(8'h62, 1'b1, 1'b1);
        push_request(8'h55, 1'b1, 1'b0);
        push_request(8'hAA, 1'b0, 1'b0);
        push_request(8'h80, 1'b1, 1'b0);
        push_request(8'h01, 1'b1, 1'b0);
        push_request(8'hFE, 1'b1, 1'b0);
        push_request(8'h7F, 1'b1, 1'b1);
        push_request(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++)
            push_request(8'hFF, 1'b1, 1'b0);
        push_request(8'h3C, 1'b0, 1'b1);
        wait_block_idle();

        write_multiplier(32'd0);
        queue_random_strings(320);
        wait_block_idle();

        no_idle_stretch = 1'b1;
        write_multiplier(32'hFFFF_FFFF);
        queue_random_strings(320);
        wait_block_idle();
        no_idle_stretch = 1'b0;

        // Receiver holds off while strings keep arriving, so the block backs up.
        write_multiplier(32'd1);
        @(negedge clk);
        long_hold_cycles = LONG_HOLD;
        queue_random_strings(330);
        wait_block_idle();

        // Sender pauses midway until every result has been checked.
        write_multiplier($urandom());
        queue_random_strings(165);
        wait_all_sent_and_checked();
        queue_random_strings(165);
        wait_block_idle();

        write_multiplier({1'b1, 31'($urandom())});
        queue_random_strings(330);
        wait_block_idle();

        if (mismatches == 0 && expected_hashes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[string_hash_bank_top.f]
+incdir+hdl
hdl/shb_pkg.sv
hdl/shb_in_stage.sv
hdl/shb_hash_core.sv
hdl/shb_out_stage.sv
hdl/string_hash_bank_top.sv
bench/string_hash_bank_top_tb.sv
